// ----- design/rdc_pkg.sv -----
// Shared types and constants for the radix digit converter.
`default_nettype none

package rdc_pkg;

  localparam int VALUE_W = 32;
  localparam int RADIX_W = 16;
  localparam int DIGIT_W = 16;
  localparam int MAG_W   = VALUE_W - 1;
  localparam int CNT_W   = $clog2(MAG_W);

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic        [RADIX_W-1:0] radix;
  } rdc_in_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               last;
    logic               bad_radix;
  } rdc_out_t;

  typedef struct packed {
    logic [MAG_W-1:0]   quo;
    logic [RADIX_W-1:0] rem;
  } rdc_div_res_t;

endpackage

`default_nettype wire

// ----- design/rdc_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none

module rdc_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [rdc_pkg::MAG_W-1:0]   dividend,
  input  wire logic [rdc_pkg::RADIX_W-1:0] divisor,
  output logic                           done,
  output rdc_pkg::rdc_div_res_t          res
);
  import rdc_pkg::*;

  logic [MAG_W-1:0]   quo_r, quo_nxt;
  logic [RADIX_W-1:0] rem_r, rem_nxt;
  logic [RADIX_W-1:0] div_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic               done_r;
  logic [RADIX_W:0]   rem_sh;
  logic [RADIX_W:0]   rem_sub;
  logic               ge;

  always_comb begin
    rem_sh  = {rem_r, quo_r[MAG_W-1]};
    ge      = rem_sh >= {1'b0, div_r};
    rem_sub = rem_sh - {1'b0, div_r};
    // partial remainder stays below the divisor, so it fits RADIX_W bits
    rem_nxt = ge ? rem_sub[RADIX_W-1:0] : rem_sh[RADIX_W-1:0];
    quo_nxt = {quo_r[MAG_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MAG_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done    = done_r;
  assign res.quo = quo_r;
  assign res.rem = rem_r;

endmodule

`default_nettype wire

// ----- design/radix_digit_converter.sv -----
// Radix digit converter top level: sequencer, held state and output register.
// Each digit word is one run of the shared divider, started when the input word is taken
// or when a non-final digit word is taken; a full conversion gives up to 31 digits.
// The shared divider sets the pace of the digit words.
// Zero or negative values are taken and give nothing; a bad radix gives its error
// word in the cycle after acceptance. Reset (rst_n low, sync) idles all.
`default_nettype none

module radix_digit_converter (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire rdc_pkg::rdc_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output rdc_pkg::rdc_out_t     out_data
);
  import rdc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } state_t;

  state_t             state_r;
  logic               out_valid_r;
  rdc_out_t           out_r;
  logic [MAG_W-1:0]   quot_r;     // remaining quotient
  logic [RADIX_W-1:0] radix_r;    // radix held for this conversion

  logic               in_take;
  logic               out_take;
  logic [MAG_W-1:0]   in_mag;
  logic               in_neg;
  logic               in_none;    // value zero or negative: no words
  logic               in_bad;     // radix below two
  logic               div_start;
  logic [MAG_W-1:0]   div_dividend;
  logic [RADIX_W-1:0] div_divisor;
  logic               div_done;
  rdc_div_res_t       div_res;

  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid_r && !out_stall;

  assign in_neg  = in_data.value[VALUE_W-1];
  assign in_mag  = in_data.value[MAG_W-1:0];
  assign in_none = in_neg || (in_mag == '0);
  assign in_bad  = (in_data.radix < RADIX_W'(2));

  // Divider starts on a good new word, or after a non-final digit is taken.
  always_comb begin
    div_start = 1'b0;
    if (state_r == ST_IDLE) begin
      div_start = in_take && !in_none && !in_bad;
    end else if (state_r == ST_OUT) begin
      div_start = out_take && !out_r.last;
    end
    div_dividend = (state_r == ST_IDLE) ? in_mag : quot_r;
    div_divisor  = (state_r == ST_IDLE) ? in_data.radix : radix_r;
  end

  rdc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .res      (div_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      out_r       <= '0;
      quot_r      <= '0;
      radix_r     <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_take && !in_none) begin
            radix_r <= in_data.radix;
            if (in_bad) begin
              // error word: digit zero, final
              out_r.digit     <= '0;
              out_r.last      <= 1'b1;
              out_r.bad_radix <= 1'b1;
              out_valid_r     <= 1'b1;
              state_r         <= ST_OUT;
            end else begin
              state_r <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            quot_r          <= div_res.quo;
            out_r.digit     <= DIGIT_W'(div_res.rem);
            out_r.last      <= (div_res.quo == '0);
            out_r.bad_radix <= 1'b0;
            out_valid_r     <= 1'b1;
            state_r         <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_take) begin
            out_valid_r <= 1'b0;
            if (out_r.last) begin
              quot_r  <= '0;
              state_r <= ST_IDLE;
            end else begin
              state_r <= ST_DIV;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ----- test/rdc_digit_checker.sv -----
// Checker for the radix digit converter: predicts digit words and compares them.
`timescale 1ns / 100ps

module rdc_digit_checker (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_stall,
  input  wire rdc_pkg::rdc_in_t  in_data,
  input  wire logic              out_valid,
  input  wire logic              out_stall,
  input  wire rdc_pkg::rdc_out_t out_data,
  output int                     fails,
  output int                     due_count
);
  import rdc_pkg::*;

  rdc_out_t digits_due[$];
  rdc_out_t want;

  initial begin
    fails     = 0;
    due_count = 0;
  end

  // Append one expected word at the tail of the queue.
  function automatic void queue_digit(input rdc_out_t d);
    digits_due.insert(digits_due.size(), d);
  endfunction

  // Digits of one accepted word, least significant first.
  function automatic void expand_digits(input rdc_in_t w);
    logic [MAG_W-1:0]   quo;
    logic [RADIX_W-1:0] base;
    rdc_out_t           d;
    quo  = w.value[MAG_W-1:0];
    base = w.radix;
    if (w.value[VALUE_W-1] || quo == '0) return;
    if (base < 2) begin
      d.digit     = '0;
      d.last      = 1'b1;
      d.bad_radix = 1'b1;
      queue_digit(d);
      return;
    end
    do begin
      d.digit     = DIGIT_W'(quo % base);
      quo         = quo / base;
      d.last      = (quo == '0);
      d.bad_radix = 1'b0;
      queue_digit(d);
    end while (quo != '0);
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) expand_digits(in_data);
      if (out_valid && !out_stall) begin
        if (digits_due.size() == 0) begin
          fails++;
          $error("digit word %0d with none due", out_data.digit);
        end else begin
          want = digits_due.pop_front();
          if (out_data.digit !== want.digit) begin
            fails++;
            $error("digit: expected %0d, got %0d", want.digit, out_data.digit);
          end
          if (out_data.last !== want.last) begin
            fails++;
            $error("last: expected %0b, got %0b", want.last, out_data.last);
          end
          if (out_data.bad_radix !== want.bad_radix) begin
            fails++;
            $error("bad_radix: expected %0b, got %0b", want.bad_radix, out_data.bad_radix);
          end
        end
      end
      due_count = digits_due.size();
    end
  end

endmodule

// ----- test/radix_digit_converter_tb.sv -----
// Testbench top for the radix digit converter: stimulus, back-pressure and verdict.
`timescale 1ns / 100ps

module radix_digit_converter_tb;
  import rdc_pkg::*;

  // Slowest correct run is roughly 250 words of up to 31 digits each; keep a wide margin.
  localparam int CYCLE_LIMIT = 2_000_000;
  // Settle time after the last digit word: longer than one full 31-digit conversion.
  localparam int DRAIN_CYCLES = 1100;
  localparam int RANDOM_WORDS = 230;
  // Receiver holds off this long once, so the converter backs up and stalls its input.
  localparam int LONG_HOLD = 600;

  logic     clk;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  rdc_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  rdc_out_t out_data;

  int fail_count;
  int due_count;
  int cycles = 0;

  radix_digit_converter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  rdc_digit_checker u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .fails     (fail_count),
    .due_count (due_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offer one input word after a random gap (none when eager), hold it until taken.
  // Valid is lowered only when a gap follows, so back-to-back words keep it high.
  task automatic offer_word(input logic signed [VALUE_W-1:0] v,
                            input logic [RADIX_W-1:0] r, input bit eager);
    int      gap;
    rdc_in_t w;
    gap     = eager ? 0 : $urandom_range(0, 14);
    w.value = v;
    w.radix = r;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= w;
    in_valid <= 1'b1;
    // Sampled right after the edge, so in_stall is the value the edge saw.
    do @(posedge clk); while (in_stall);
  endtask

  // Result side: random stall before each word, quiet stretches with no stall,
  // and one long hold-off early on to back the converter up.
  initial begin : drain
    int hold;
    int taken;
    taken = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken == 40) hold = LONG_HOLD;
      else if ((taken % 50) >= 35) hold = 0;
      else hold = $urandom_range(0, 14);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  initial begin : stimulus
    int                          made;
    int                          pick;
    bit                          eager;
    logic signed [VALUE_W-1:0]   v;
    logic        [RADIX_W-1:0]   r;
    logic        [MAG_W-1:0]     mag;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, the no-result and bad-radix cases, longest conversion.
    offer_word(32'sd0,           16'd10,    1'b0);  // zero value, nothing out
    offer_word(-32'sd1,          16'd10,    1'b0);  // all ones, negative
    offer_word(32'sh8000_0000,   16'd2,     1'b0);  // most negative
    offer_word(-32'sd5,          16'd0,     1'b0);  // negative beats bad radix
    offer_word(32'sd0,           16'd0,     1'b1);  // zero beats bad radix
    offer_word(32'sh7FFF_FFFF,   16'd2,     1'b1);  // 31 digits, all ones
    offer_word(32'sd1,           16'd0,     1'b0);  // bad radix, zero
    offer_word(32'sd1,           16'd1,     1'b1);  // bad radix, one
    offer_word(32'sh7FFF_FFFF,   16'd0,     1'b0);  // bad radix, largest value
    offer_word(32'sd1,           16'd2,     1'b0);  // single digit
    offer_word(32'sh7FFF_FFFF,   16'hFFFF,  1'b0);  // widest radix
    offer_word(32'sd65534,       16'hFFFF,  1'b1);  // largest digit
    offer_word(32'sd65535,       16'hFFFF,  1'b0);  // digits 0 then 1
    offer_word(32'sd12345,       16'd10,    1'b0);
    offer_word(32'sd255,         16'd16,    1'b1);
    offer_word(32'sd256,         16'd16,    1'b1);
    offer_word(32'sh7FFF_FFFF,   16'd3,     1'b0);
    offer_word(32'sh5555_5555,   16'd36,    1'b0);
    offer_word(32'sh2AAA_AAAA,   16'h8000,  1'b1);
    offer_word(32'sd2,           16'hFFFE,  1'b0);

    // Random: mostly positive values of random length against a spread of radices,
    // some noise (zero, negative, bad radix).
    made = 0;
    while (made < RANDOM_WORDS) begin
      eager = (made % 60) >= 45;
      pick  = $urandom_range(0, 99);
      mag   = MAG_W'($urandom() >> $urandom_range(0, 31));
      if (mag == '0) mag = MAG_W'(1);
      v = {1'b0, mag};
      if ($urandom_range(0, 1) == 0) r = RADIX_W'($urandom_range(2, 16));
      else if ($urandom_range(0, 1) == 0) r = RADIX_W'($urandom_range(2, 65535));
      else r = RADIX_W'(1 << $urandom_range(1, 15));
      if (pick < 6) begin
        v = $urandom() | 32'h8000_0000;
        r = RADIX_W'($urandom());
      end else if (pick < 10) begin
        v = '0;
        r = RADIX_W'($urandom());
      end else if (pick < 16) begin
        r = RADIX_W'($urandom_range(0, 1));
      end
      offer_word(v, r, eager);
      made++;
    end
    in_valid <= 1'b0;

    // Let the checker see the last accepted word, then wait out every expected digit.
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
